// ===== rtl/gbn_pkg.sv =====
// Shared types and constants for the go-back-N sender window.
// Used by gbn_alu and go_back_n_sender_window; depends on nothing else.
package gbn_pkg;

	// Operations of the shared sequence-number adder.
	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_INC = 2'd2
	} alu_op_t;

	localparam int CMD_W = 2;
	localparam int WIN_W = 4;
	localparam int TMR_W = 2;
	localparam int SEQ_FIELD_W = 16;

	localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

	localparam logic [TMR_W-1:0] TMR_NONE  = 2'd0;
	localparam logic [TMR_W-1:0] TMR_START = 2'd1;
	localparam logic [TMR_W-1:0] TMR_STOP  = 2'd2;

	localparam logic [WIN_W-1:0] WIN_RESET = 4'd4;

endpackage

// ===== rtl/gbn_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the outstanding payloads of the sender window; no dependencies.
module gbn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/gbn_alu.sv =====
// Shared modular adder/subtractor for sequence numbers and window counts.
// Depends on gbn_pkg for the operation codes.
module gbn_alu #(
	parameter int W = 16
) (
	input  gbn_pkg::alu_op_t op,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	output logic [W-1:0]     sum,
	output logic             carry
);
	import gbn_pkg::*;

	logic [W-1:0] b_x;
	logic         cin;

	always_comb begin
		unique case (op)
			ALU_ADD: begin
				b_x = b;
				cin = 1'b0;
			end
			ALU_SUB: begin
				b_x = ~b;
				cin = 1'b1;
			end
			ALU_INC: begin
				b_x = '0;
				cin = 1'b1;
			end
			default: begin
				b_x = b;
				cin = 1'b0;
			end
		endcase
	end

	// For a subtraction the carry out is set when a >= b.
	assign {carry, sum} = {1'b0, a} + {1'b0, b_x} + (W+1)'(cin);

endmodule

// ===== rtl/go_back_n_sender_window.sv =====
// Top level of the go-back-N sender window: sequencer, state and result register.
// Depends on gbn_pkg, gbn_alu and gbn_ram.
//
// The block takes one transaction at a time and holds s_tready low until every
// result of it has been taken. All sequence arithmetic and window compares go
// through one shared adder, one operation per cycle. Every command first forms
// the outstanding count and the window-full flag; a send then advances the next
// sequence number and forms both again, and an acknowledgement takes its offset
// from the base, compares it with the outstanding count and, if accepted, moves
// the base and forms both again. A timeout replays each outstanding packet with
// an adder step and a registered read of the payload RAM.
// The payload RAM needs no clearing after reset.
module go_back_n_sender_window #(
	parameter int WINDOW_DEPTH = 8,
	parameter int SEQ_BITS = 16,
	parameter int PAYLOAD_BITS = 32,
	localparam int IN_W = ((PAYLOAD_BITS + 17 + 7) / 8) * 8,
	localparam int OUT_W = ((PAYLOAD_BITS + 37 + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [gbn_pkg::WIN_W-1:0]        cfg_wr_data,   // window_size
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// payload, ack_number, ack_intact
	input  logic [IN_W-1:0]                  s_tdata,
	input  logic [gbn_pkg::CMD_W-1:0]        s_tuser,       // command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// accepted, window_full, packet_valid, packet_seq, packet_data,
	// timer_action, timer_seq
	output logic [OUT_W-1:0]                 m_tdata,
	output logic                             m_tlast
);
	import gbn_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int SLOT_X = SLOT_W + 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam logic [SLOT_X-1:0] DEPTH_X = SLOT_X'(WINDOW_DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b0000_0000_0001,
		ST_OUTST    = 12'b0000_0000_0010,
		ST_FULL     = 12'b0000_0000_0100,
		ST_SEND     = 12'b0000_0000_1000,
		ST_OFF      = 12'b0000_0001_0000,
		ST_OFFCMP   = 12'b0000_0010_0000,
		ST_ACKUPD   = 12'b0000_0100_0000,
		ST_REF_OUT  = 12'b0000_1000_0000,
		ST_REF_FULL = 12'b0001_0000_0000,
		ST_RD       = 12'b0010_0000_0000,
		ST_LOAD     = 12'b0100_0000_0000,
		ST_EMIT     = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// Window state.
	logic [WIN_W-1:0]    window_q;
	logic [SEQ_BITS-1:0] base_seq_q;
	logic [SEQ_BITS-1:0] next_seq_q;
	logic [SLOT_W-1:0]   base_slot_q;

	// Captured input transaction and intermediate values.
	logic [CMD_W-1:0]        cmd_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic [SEQ_BITS-1:0]     ack_q;
	logic                    intact_q;
	logic [SEQ_BITS-1:0]     outst_q;
	logic [SEQ_BITS-1:0]     off_q;
	logic                    full_q;
	logic [CNT_W-1:0]        idx_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SLOT_W-1:0]       rd_slot_q;

	// Result register.
	logic                    acc_q;
	logic                    pv_q;
	logic [SEQ_FIELD_W-1:0]  pseq_q;
	logic [PAYLOAD_BITS-1:0] pdata_q;
	logic [TMR_W-1:0]        tact_q;
	logic [SEQ_FIELD_W-1:0]  tseq_q;
	logic                    last_q;

	logic [WIN_W-1:0]        eff_win;
	alu_op_t                 alu_op;
	logic [SEQ_BITS-1:0]     alu_a;
	logic [SEQ_BITS-1:0]     alu_b;
	logic [SEQ_BITS-1:0]     alu_sum;
	logic                    alu_carry;

	logic                    ram_we;
	logic [SLOT_W-1:0]       ram_waddr;
	logic                    ram_re;
	logic [PAYLOAD_BITS-1:0] ram_rdata;

	logic                    in_fire;
	logic                    out_fire;

	function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_X-1:0] s);
		return (s >= DEPTH_X) ? SLOT_W'(s - DEPTH_X) : SLOT_W'(s);
	endfunction

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tlast  = last_q;
	assign m_tdata  = OUT_W'({tseq_q, tact_q, pdata_q, pseq_q, pv_q, full_q, acc_q});

	// A zero window acts as one; a window beyond the store is clipped to it.
	always_comb begin
		if (window_q == '0) begin
			eff_win = WIN_W'(1);
		end else if (32'(window_q) > WINDOW_DEPTH) begin
			eff_win = WIN_W'(WINDOW_DEPTH);
		end else begin
			eff_win = window_q;
		end
	end

	always_comb begin
		unique case (state_q)
			ST_OUTST, ST_REF_OUT: begin
				alu_op = ALU_SUB;
				alu_a  = next_seq_q;
				alu_b  = base_seq_q;
			end
			ST_FULL, ST_REF_FULL: begin
				alu_op = ALU_SUB;
				alu_a  = outst_q;
				alu_b  = SEQ_BITS'(eff_win);
			end
			ST_SEND: begin
				alu_op = ALU_INC;
				alu_a  = next_seq_q;
				alu_b  = '0;
			end
			ST_OFF: begin
				alu_op = ALU_SUB;
				alu_a  = ack_q;
				alu_b  = base_seq_q;
			end
			ST_OFFCMP: begin
				alu_op = ALU_SUB;
				alu_a  = off_q;
				alu_b  = outst_q;
			end
			ST_ACKUPD: begin
				alu_op = ALU_INC;
				alu_a  = ack_q;
				alu_b  = '0;
			end
			ST_RD: begin
				alu_op = ALU_ADD;
				alu_a  = base_seq_q;
				alu_b  = SEQ_BITS'(idx_q);
			end
			default: begin
				alu_op = ALU_ADD;
				alu_a  = '0;
				alu_b  = '0;
			end
		endcase
	end

	gbn_alu #(
		.W(SEQ_BITS)
	) u_alu (
		.op   (alu_op),
		.a    (alu_a),
		.b    (alu_b),
		.sum  (alu_sum),
		.carry(alu_carry)
	);

	assign ram_we    = (state_q == ST_SEND);
	assign ram_waddr = wrap_slot({1'b0, base_slot_q} + SLOT_X'(outst_q));
	assign ram_re    = (state_q == ST_RD);

	gbn_ram #(
		.WIDTH(PAYLOAD_BITS),
		.DEPTH(WINDOW_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(payload_q),
		.re   (ram_re),
		.raddr(rd_slot_q),
		.rdata(ram_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= WIN_RESET;
			base_seq_q  <= SEQ_BITS'(1);
			next_seq_q  <= SEQ_BITS'(1);
			base_slot_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				window_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_OUTST;
					end
				end
				ST_OUTST: state_q <= ST_FULL;
				ST_FULL: begin
					unique case (cmd_q)
						CMD_SEND:    state_q <= alu_carry ? ST_EMIT : ST_SEND;
						CMD_ACK:     state_q <= ST_OFF;
						CMD_TIMEOUT: state_q <= (outst_q == '0) ? ST_EMIT : ST_RD;
						CMD_NOP:     state_q <= ST_EMIT;
						default:     state_q <= ST_EMIT;
					endcase
				end
				ST_SEND: begin
					next_seq_q <= alu_sum;
					state_q    <= ST_REF_OUT;
				end
				ST_OFF: state_q <= ST_OFFCMP;
				ST_OFFCMP: begin
					state_q <= (!intact_q || alu_carry) ? ST_EMIT : ST_ACKUPD;
				end
				ST_ACKUPD: begin
					base_seq_q  <= alu_sum;
					base_slot_q <= wrap_slot({1'b0, base_slot_q} + SLOT_X'(off_q) + SLOT_X'(1));
					state_q     <= ST_REF_OUT;
				end
				ST_REF_OUT:  state_q <= ST_REF_FULL;
				ST_REF_FULL: state_q <= ST_EMIT;
				ST_RD:       state_q <= ST_LOAD;
				ST_LOAD:     state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_fire) begin
						state_q <= (cmd_q == CMD_TIMEOUT && !last_q) ? ST_RD : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath and result registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd_q     <= s_tuser;
					payload_q <= s_tdata[PAYLOAD_BITS-1:0];
					ack_q     <= SEQ_BITS'(s_tdata[PAYLOAD_BITS +: SEQ_FIELD_W]);
					intact_q  <= s_tdata[PAYLOAD_BITS + SEQ_FIELD_W];
				end
			end
			ST_OUTST: outst_q <= alu_sum;
			ST_FULL: begin
				full_q  <= alu_carry;
				acc_q   <= 1'b0;
				pv_q    <= 1'b0;
				pseq_q  <= '0;
				pdata_q <= '0;
				tact_q  <= TMR_NONE;
				tseq_q  <= '0;
				last_q  <= 1'b1;
				if (cmd_q == CMD_TIMEOUT) begin
					idx_q     <= '0;
					cnt_q     <= CNT_W'(outst_q);
					rd_slot_q <= base_slot_q;
					if (outst_q == '0) begin
						tact_q <= TMR_START;
						tseq_q <= SEQ_FIELD_W'(base_seq_q);
					end
				end
			end
			ST_SEND: begin
				acc_q   <= 1'b1;
				pv_q    <= 1'b1;
				pseq_q  <= SEQ_FIELD_W'(next_seq_q);
				pdata_q <= payload_q;
				// The new packet is the window base exactly when nothing was outstanding.
				if (outst_q == '0) begin
					tact_q <= TMR_START;
					tseq_q <= SEQ_FIELD_W'(base_seq_q);
				end
			end
			ST_OFF: off_q <= alu_sum;
			ST_ACKUPD: begin
				acc_q  <= 1'b1;
				tact_q <= TMR_STOP;
				tseq_q <= SEQ_FIELD_W'(base_seq_q);
			end
			ST_REF_OUT: outst_q <= alu_sum;
			ST_REF_FULL: begin
				full_q <= alu_carry;
				if (cmd_q == CMD_ACK && outst_q != '0) begin
					tact_q <= TMR_START;
					tseq_q <= SEQ_FIELD_W'(base_seq_q);
				end
			end
			ST_RD: begin
				pv_q   <= 1'b1;
				pseq_q <= SEQ_FIELD_W'(alu_sum);
				last_q <= (idx_q + CNT_W'(1)) == cnt_q;
				if (idx_q == '0) begin
					tact_q <= TMR_START;
					tseq_q <= SEQ_FIELD_W'(base_seq_q);
				end else begin
					tact_q <= TMR_NONE;
					tseq_q <= '0;
				end
			end
			ST_LOAD: pdata_q <= ram_rdata;
			ST_EMIT: begin
				if (out_fire) begin
					idx_q     <= idx_q + CNT_W'(1);
					rd_slot_q <= (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + SLOT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule
